### design/msp_pkg.sv
`default_nettype none

package msp_pkg;

   localparam int LETTER_W     = 5;
   localparam int WORD_W       = 64;
   localparam int LETTER_COUNT = 26;
   localparam int CODE_MAX     = 4;
   localparam int CODE_LEN_W   = 3;

   localparam logic [1:0] SYM_GAP = 2'd2;
   localparam logic [1:0] SYM_END = 2'd3;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [CODE_LEN_W-1:0] len;
      logic [CODE_MAX-1:0]   elems;
   } code_type;

   typedef struct packed {
      logic [WORD_W-1:0] packed_word;
      logic              final_word;
   } rsp_entry_type;

   typedef struct packed {
      logic [1:0]    rsp_count;
      rsp_entry_type first;
      rsp_entry_type second;
   } pack_out_type;

   // elems: dash 1, dot 0, right aligned, earliest element in the top used bit
   function automatic code_type morse_code(input logic [LETTER_W-1:0] letter);
      code_type c;
      c.len   = 3'd0;
      c.elems = 4'b0000;
      unique case (letter)
         5'd0:    begin c.len = 3'd2; c.elems = 4'b0001; end
         5'd1:    begin c.len = 3'd4; c.elems = 4'b1000; end
         5'd2:    begin c.len = 3'd4; c.elems = 4'b1010; end
         5'd3:    begin c.len = 3'd3; c.elems = 4'b0100; end
         5'd4:    begin c.len = 3'd1; c.elems = 4'b0000; end
         5'd5:    begin c.len = 3'd4; c.elems = 4'b0010; end
         5'd6:    begin c.len = 3'd3; c.elems = 4'b0110; end
         5'd7:    begin c.len = 3'd4; c.elems = 4'b0000; end
         5'd8:    begin c.len = 3'd2; c.elems = 4'b0000; end
         5'd9:    begin c.len = 3'd4; c.elems = 4'b0111; end
         5'd10:   begin c.len = 3'd3; c.elems = 4'b0101; end
         5'd11:   begin c.len = 3'd4; c.elems = 4'b0100; end
         5'd12:   begin c.len = 3'd2; c.elems = 4'b0011; end
         5'd13:   begin c.len = 3'd2; c.elems = 4'b0010; end
         5'd14:   begin c.len = 3'd3; c.elems = 4'b0111; end
         5'd15:   begin c.len = 3'd4; c.elems = 4'b0110; end
         5'd16:   begin c.len = 3'd4; c.elems = 4'b1101; end
         5'd17:   begin c.len = 3'd3; c.elems = 4'b0010; end
         5'd18:   begin c.len = 3'd3; c.elems = 4'b0000; end
         5'd19:   begin c.len = 3'd1; c.elems = 4'b0001; end
         5'd20:   begin c.len = 3'd3; c.elems = 4'b0001; end
         5'd21:   begin c.len = 3'd4; c.elems = 4'b0001; end
         5'd22:   begin c.len = 3'd3; c.elems = 4'b0011; end
         5'd23:   begin c.len = 3'd4; c.elems = 4'b1001; end
         5'd24:   begin c.len = 3'd4; c.elems = 4'b1011; end
         5'd25:   begin c.len = 3'd4; c.elems = 4'b1100; end
         default: begin c.len = 3'd0; c.elems = 4'b0000; end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### design/msp_req_if.sv
`default_nettype none

interface msp_req_if;
   logic                          valid;
   logic                          ready;
   logic [msp_pkg::LETTER_W-1:0]  letter;
   logic                          last_letter;

   modport source (output valid, output letter, output last_letter, input ready);
   modport sink   (input valid, input letter, input last_letter, output ready);
endinterface

`default_nettype wire

### design/msp_rsp_if.sv
`default_nettype none

interface msp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [msp_pkg::WORD_W-1:0]  packed_word;
   logic                        final_word;

   modport source (output valid, output packed_word, output final_word, input ready);
   modport sink   (input valid, input packed_word, input final_word, output ready);
endinterface

`default_nettype wire

### design/msp_pack.sv
`default_nettype none

module msp_pack #(
   parameter int SYMBOLS_PER_WORD = 32
) (
   input  logic [2*SYMBOLS_PER_WORD-1:0]         acc,
   input  logic [$clog2(SYMBOLS_PER_WORD)-1:0]   count,
   input  logic [msp_pkg::LETTER_W-1:0]          letter,
   input  logic                                  last_letter,
   output logic [2*SYMBOLS_PER_WORD-1:0]         acc_next,
   output logic [$clog2(SYMBOLS_PER_WORD)-1:0]   count_next,
   output msp_pkg::pack_out_type                 result
);
   import msp_pkg::*;

   localparam int W     = SYMBOLS_PER_WORD;
   localparam int WB    = 2 * W;
   localparam int CW    = WB + 8;
   localparam int CNT_W = $clog2(W);
   localparam int TOT_W = $clog2(2 * W + 1);
   localparam int NEW_W = 2 * (CODE_MAX + 1);

   code_type           code;
   logic               letter_ok;
   logic               ignore;
   logic [2:0]         sym_count;
   logic [3:0]         new_sh;
   logic [NEW_W-1:0]   new_bits;
   logic [CW-1:0]      combined;
   logic [TOT_W-1:0]   total;
   logic               emit1;
   logic               emit2;
   logic [TOT_W-1:0]   sh1;
   logic [TOT_W-1:0]   sh2;
   logic [TOT_W-1:0]   rem;
   logic [CW-1:0]      shifted_a;
   logic [CW-1:0]      shifted_b;
   logic [CW-1:0]      rem_bits;
   logic [WB-1:0]      word_a;
   logic [WB-1:0]      word_b;
   logic [WB-1:0]      rem_word;
   logic [TOT_W:0]     pad_sh;
   logic [WB-1:0]      final_w;

   always_comb begin
      code      = morse_code(letter);
      letter_ok = (letter < LETTER_W'(LETTER_COUNT));
      ignore    = !letter_ok && !last_letter;
      sym_count = code.len + 3'd1;
      new_sh    = {sym_count, 1'b0};

      new_bits = '0;
      for (int j = 0; j < CODE_MAX; j++) begin
         new_bits[2*j+2 +: 2] = {1'b0, code.elems[j]};
      end
      new_bits[1:0] = last_letter ? SYM_END : SYM_GAP;

      combined = (CW'(acc) << new_sh) | CW'(new_bits);
      total    = TOT_W'(count) + TOT_W'(sym_count);

      emit1 = last_letter ? (total > TOT_W'(W)) : (total >= TOT_W'(W));
      emit2 = !last_letter && (total >= TOT_W'(2 * W));

      sh1 = total - TOT_W'(W);
      sh2 = total - TOT_W'(2 * W);
      if (emit2) begin
         rem = sh2;
      end else if (emit1) begin
         rem = sh1;
      end else begin
         rem = total;
      end

      shifted_a = combined >> {sh1, 1'b0};
      shifted_b = combined >> {sh2, 1'b0};
      word_a    = shifted_a[WB-1:0];
      word_b    = shifted_b[WB-1:0];
      rem_bits  = combined & ~({CW{1'b1}} << {rem, 1'b0});
      rem_word  = rem_bits[WB-1:0];

      pad_sh  = {TOT_W'(W) - rem, 1'b0};
      final_w = (rem_word << pad_sh) | ~({WB{1'b1}} << pad_sh);

      if (ignore) begin
         result.rsp_count = 2'd0;
      end else begin
         result.rsp_count = 2'(emit1) + 2'(emit2) + 2'(last_letter);
      end
      result.first.packed_word  = WORD_W'(emit1 ? word_a : final_w);
      result.first.final_word   = last_letter && !emit1;
      result.second.packed_word = WORD_W'(emit2 ? word_b : final_w);
      result.second.final_word  = last_letter;

      if (last_letter) begin
         acc_next   = '0;
         count_next = '0;
      end else if (ignore) begin
         acc_next   = acc;
         count_next = count;
      end else begin
         acc_next   = rem_word;
         count_next = rem[CNT_W-1:0];
      end
   end

endmodule

`default_nettype wire

### design/msp_rsp_queue.sv
`default_nettype none

module msp_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  msp_pkg::pack_out_type push,
   output logic                  room,
   msp_rsp_if.source             rsp_bus
);
   import msp_pkg::*;

   rsp_entry_type          entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   wr_ptr_nxt;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;
   logic                   pop;

   assign pop                 = rsp_bus.valid && rsp_bus.ready;
   assign room                = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign rsp_bus.valid       = (count_ff != '0);
   assign rsp_bus.packed_word = entry_ff[rd_ptr_ff].packed_word;
   assign rsp_bus.final_word  = entry_ff[rd_ptr_ff].final_word;

   assign wr_ptr_nxt = wr_ptr_ff + RSP_PTR_W'(1);
   assign wr_ptr_in  = wr_ptr_ff + RSP_PTR_W'(push.rsp_count);
   assign rd_ptr_in  = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in   = count_ff + RSP_CNT_W'(push.rsp_count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.rsp_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.rsp_count == 2'd2) begin
         entry_ff[wr_ptr_nxt] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/morse_symbol_packer.sv
`default_nettype none

// Morse symbol packer. Takes one letter (0 = A .. 25 = Z) per transaction and
// packs its Morse elements as 2-bit symbols (dot 0, dash 1, gap 2, end 3) into
// words of SYMBOLS_PER_WORD symbols, earliest symbol in the top used bits and
// zeros above. A letter is accepted every cycle unless req_bus stalls: it is
// held in an input register, then encoded and packed in a single pass into a
// four-entry response queue, from which its words reach rsp_bus. A letter
// yields zero, one or two words; the queue drains one word per cycle while
// rsp_bus.ready is high, so two-word letters take double response bandwidth;
// req_bus stalls only while the queue lacks room for two words. A letter with
// last_letter set closes the message with an end symbol, pads the open word
// with end symbols and returns it flagged final_word. Letter codes 26 to 31
// are dropped unless marked last, in which case they only close the message.

module morse_symbol_packer #(
   parameter int SYMBOLS_PER_WORD = 32
) (
   input  logic       clock,
   input  logic       reset,
   msp_req_if.sink    req_bus,
   msp_rsp_if.source  rsp_bus
);
   import msp_pkg::*;

   localparam int WB    = 2 * SYMBOLS_PER_WORD;
   localparam int CNT_W = $clog2(SYMBOLS_PER_WORD);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [LETTER_W-1:0]   letter_ff;
   logic                  last_ff;
   logic [WB-1:0]         acc_ff;
   logic [WB-1:0]         acc_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  room;
   logic                  fire;
   logic                  take;
   pack_out_type          pack_out;
   pack_out_type          push;

   assign fire          = in_valid_ff && room;
   assign req_bus.ready = !in_valid_ff || fire;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         letter_ff <= req_bus.letter;
         last_ff   <= req_bus.last_letter;
      end
   end

   msp_pack #(
      .SYMBOLS_PER_WORD (SYMBOLS_PER_WORD)
   ) u_pack (
      .acc         (acc_ff),
      .count       (count_ff),
      .letter      (letter_ff),
      .last_letter (last_ff),
      .acc_next    (acc_in),
      .count_next  (count_in),
      .result      (pack_out)
   );

   always_comb begin
      push = pack_out;
      if (!fire) begin
         push.rsp_count = 2'd0;
      end
   end

   msp_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff      <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            acc_ff   <= acc_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

### tb/morse_symbol_packer_checker.sv
`timescale 1ns / 100ps

module morse_symbol_packer_checker #(
   parameter int SYMBOLS_PER_WORD = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [msp_pkg::LETTER_W-1:0] req_letter,
   input  logic                        req_last_letter,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [msp_pkg::WORD_W-1:0]  rsp_packed_word,
   input  logic                        rsp_final_word,
   output int                          failures,
   output int                          words_pending
);
   import msp_pkg::*;

   localparam logic [1:0] SYM_DOT  = 2'd0;
   localparam logic [1:0] SYM_DASH = 2'd1;
   localparam logic [WORD_W-1:0] WORD_MASK =
      {WORD_W{1'b1}} >> (WORD_W - 2 * SYMBOLS_PER_WORD);

   logic [WORD_W-1:0] open_word;
   int                open_count;
   rsp_entry_type     expected_words [$];
   rsp_entry_type     want;
   int                mismatch_count;

   function automatic string morse_elements(input logic [LETTER_W-1:0] letter);
      case (letter)
         5'd0:    return ".-";
         5'd1:    return "-...";
         5'd2:    return "-.-.";
         5'd3:    return "-..";
         5'd4:    return ".";
         5'd5:    return "..-.";
         5'd6:    return "--.";
         5'd7:    return "....";
         5'd8:    return "..";
         5'd9:    return ".---";
         5'd10:   return "-.-";
         5'd11:   return ".-..";
         5'd12:   return "--";
         5'd13:   return "-.";
         5'd14:   return "---";
         5'd15:   return ".--.";
         5'd16:   return "--.-";
         5'd17:   return ".-.";
         5'd18:   return "...";
         5'd19:   return "-";
         5'd20:   return "..-";
         5'd21:   return "...-";
         5'd22:   return ".--";
         5'd23:   return "-..-";
         5'd24:   return "-.--";
         5'd25:   return "--..";
         default: return "";
      endcase
   endfunction

   function automatic void close_word(input logic fin);
      rsp_entry_type entry;
      entry.packed_word = open_word & WORD_MASK;
      entry.final_word  = fin;
      expected_words.push_back(entry);
      open_word  = '0;
      open_count = 0;
   endfunction

   function automatic void append_symbol(input logic [1:0] sym, input bit hold);
      open_word  = ((open_word << 2) | WORD_W'(sym)) & WORD_MASK;
      open_count = open_count + 1;
      if (open_count >= SYMBOLS_PER_WORD && !hold) begin
         close_word(1'b0);
      end
   endfunction

   function automatic void pack_letter(input logic [LETTER_W-1:0] letter,
                                       input logic last);
      string elements;
      if (letter >= LETTER_COUNT && !last) begin
         return;
      end
      elements = morse_elements(letter);
      for (int i = 0; i < elements.len(); i++) begin
         append_symbol((elements[i] == "-") ? SYM_DASH : SYM_DOT, 1'b0);
      end
      if (!last) begin
         append_symbol(SYM_GAP, 1'b0);
      end else begin
         append_symbol(SYM_END, 1'b1);
         // pad the open word with end symbols
         while (open_count < SYMBOLS_PER_WORD) begin
            open_word  = ((open_word << 2) | WORD_W'(SYM_END)) & WORD_MASK;
            open_count = open_count + 1;
         end
         close_word(1'b1);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         open_word      = '0;
         open_count     = 0;
         mismatch_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected word: expected none, actual %h final %b",
                        $time, rsp_packed_word, rsp_final_word);
            end else begin
               want = expected_words.pop_front();
               if (rsp_packed_word !== want.packed_word) begin
                  mismatch_count++;
                  $display("%0t: packed_word mismatch: expected %h, actual %h",
                           $time, want.packed_word, rsp_packed_word);
               end
               if (rsp_final_word !== want.final_word) begin
                  mismatch_count++;
                  $display("%0t: final_word mismatch: expected %b, actual %b",
                           $time, want.final_word, rsp_final_word);
               end
            end
         end
         if (req_valid && req_ready) begin
            pack_letter(req_letter, req_last_letter);
         end
      end
      failures      <= mismatch_count;
      words_pending <= expected_words.size();
   end

endmodule

### tb/morse_symbol_packer_test.sv
`timescale 1ns / 100ps

module morse_symbol_packer_test;
   import msp_pkg::*;

   logic clock = 1'b0;
   logic reset;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   int   letters_sent       = 0;
   int   failures;
   int   words_pending;

   msp_req_if req_bus ();
   msp_rsp_if rsp_bus ();

   morse_symbol_packer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   morse_symbol_packer_checker word_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_letter      (req_bus.letter),
      .req_last_letter (req_bus.last_letter),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_packed_word (rsp_bus.packed_word),
      .rsp_final_word  (rsp_bus.final_word),
      .failures        (failures),
      .words_pending   (words_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [LETTER_W-1:0] letter_index(input byte c);
      return LETTER_W'(c - "A");
   endfunction

   task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.letter      <= letter;
      req_bus.last_letter <= last;
      do @(posedge clock); while (!req_bus.ready);
      if (letter < LETTER_COUNT || last) begin
         letters_sent++;
      end
   endtask

   task automatic send_message();
      int length;
      length = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 1; i < length; i++) begin
         // drop in an out-of-range letter now and then
         if ($urandom_range(19) == 0) begin
            send_letter(LETTER_W'($urandom_range(26, 31)), 1'b0);
         end
         send_letter(LETTER_W'($urandom_range(LETTER_COUNT - 1)), 1'b0);
      end
      if ($urandom_range(9) == 0) begin
         send_letter(LETTER_W'($urandom_range(26, 31)), 1'b1);
      end else begin
         send_letter(LETTER_W'($urandom_range(LETTER_COUNT - 1)), 1'b1);
      end
   endtask

   initial begin
      int idle_plan  [4] = '{0, 58, 0, 16};
      int stall_plan [4] = '{0, 0, 58, 16};
      int target;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.letter      <= '0;
      req_bus.last_letter <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end symbol fills the word exactly
      repeat (6) send_letter(letter_index("H"), 1'b0);
      send_letter(letter_index("T"), 1'b1);
      // full word inside a last letter, then the padded final word
      repeat (5) send_letter(letter_index("H"), 1'b0);
      send_letter(letter_index("I"), 1'b0);
      send_letter(letter_index("B"), 1'b1);
      send_letter(letter_index("A"), 1'b0);
      send_letter(letter_index("Z"), 1'b1);
      send_letter(5'd31, 1'b1);
      send_letter(letter_index("A"), 1'b0);
      send_letter(5'd26, 1'b0);
      send_letter(letter_index("Z"), 1'b1);

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct    = idle_plan[p];
         receiver_stall_pct = stall_plan[p];
         target             = letters_sent + 220;
         while (letters_sent < target) begin
            send_message();
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0 && words_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
